### sv/focv_pkg.sv
`default_nettype none

package focv_pkg;

  // field widths
  localparam int SPEED_W = 16;
  localparam int ELAPSED_W = 32;
  localparam int DUTY_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAIR_COUNT     = 2'd0,
    CFG_ZERO_OFFSET    = 2'd1,
    CFG_DRIVE_FRACTION = 2'd2
  } cfg_idx_t;

  // configuration reset values
  localparam logic [5:0]  PAIR_COUNT_RST = 6'd7;
  localparam logic [15:0] ZERO_OFFSET_RST = 16'd0;
  localparam logic [15:0] DRIVE_FRACTION_RST = 16'd21845;

  // elapsed time guard
  localparam logic [31:0] DT_MAX_US = 32'd500000;
  localparam logic [18:0] DT_DEFAULT_US = 19'd1000;

  // about 2^48 / (2 pi 10^6)
  localparam logic [25:0] SPEED_GAIN = 26'd44798134;
  localparam logic [15:0] SQRT3_HALF_Q16 = 16'd56756;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // quarter-wave sine table
  localparam int SINE_DEPTH = 256;
  localparam int SINE_DEPTH_BITS = $clog2(SINE_DEPTH);

  typedef logic [16:0] qtab_t [0:SINE_DEPTH];

  // integer taylor series in q30, rounded to q16, worked out at elaboration
  function automatic qtab_t build_qtab();
    qtab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned mag;
    longint signed sum;
    longint unsigned v;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x = HALF_PI_Q30 * longint'(i) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      mag = x;
      sum = longint'(x);
      mag = ((mag * x2) >> 30) / 6;
      sum = sum - longint'(mag);
      mag = ((mag * x2) >> 30) / 20;
      sum = sum + longint'(mag);
      mag = ((mag * x2) >> 30) / 42;
      sum = sum - longint'(mag);
      mag = ((mag * x2) >> 30) / 72;
      sum = sum + longint'(mag);
      mag = ((mag * x2) >> 30) / 110;
      sum = sum - longint'(mag);
      mag = ((mag * x2) >> 30) / 156;
      sum = sum + longint'(mag);
      v = (sum > 0) ? ((longint'(sum) + 64'd8192) >> 14) : 64'd0;
      if (v > 64'd65536) begin
        v = 64'd65536;
      end
      tab[i] = v[16:0];
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

`default_nettype wire

### sv/focv_if.sv
`default_nettype none

// input tick channel
interface focv_in_if;
  import focv_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SPEED_W-1:0]  target_speed;
  logic [ELAPSED_W-1:0]       elapsed_us;
  modport source (output valid, target_speed, elapsed_us, input ready);
  modport sink (input valid, target_speed, elapsed_us, output ready);
endinterface

// result channel
interface focv_out_if;
  import focv_pkg::*;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_a;
  logic [DUTY_W-1:0] duty_b;
  logic [DUTY_W-1:0] duty_c;
  logic [15:0]       electrical_angle;
  modport source (output valid, duty_a, duty_b, duty_c, electrical_angle, input ready);
  modport sink (input valid, duty_a, duty_b, duty_c, electrical_angle, output ready);
endinterface

// register write channel
interface focv_cfg_if;
  import focv_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/focv_mul.sv
`default_nettype none

module focv_mul (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [35:0] a,
  input  wire logic signed [26:0] b,
  output logic signed [62:0]      p
);

  // shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

`default_nettype wire

### sv/focv_sine.sv
`default_nettype none

module focv_sine #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic [ANGLE_BITS-1:0] angle,
  output logic signed [17:0]         sin_val,
  output logic signed [17:0]         cos_val
);
  import focv_pkg::*;

  localparam int QBITS = ANGLE_BITS - 2;

  // quadrant mirror and sign around the quarter-wave table
  function automatic logic signed [17:0] sine_of(input logic [ANGLE_BITS-1:0] ph);
    logic [1:0]                 quad;
    logic [SINE_DEPTH_BITS-1:0] idx;
    logic [SINE_DEPTH_BITS:0]   idx_m;
    logic [16:0]                mag;
    quad = ph[ANGLE_BITS-1 -: 2];
    idx = ph[QBITS-1 -: SINE_DEPTH_BITS];
    if (quad[0]) begin
      idx_m = (SINE_DEPTH_BITS+1)'(SINE_DEPTH) - (SINE_DEPTH_BITS+1)'(idx);
    end else begin
      idx_m = (SINE_DEPTH_BITS+1)'(idx);
    end
    mag = QTAB[idx_m];
    if (quad[1]) begin
      return 18'sd0 - signed'({1'b0, mag});
    end else begin
      return signed'({1'b0, mag});
    end
  endfunction

  logic [ANGLE_BITS-1:0] angle_cos;

  // cosine is sine a quarter turn on
  assign angle_cos = angle + ANGLE_BITS'(1 << QBITS);
  assign sin_val = sine_of(angle);
  assign cos_val = sine_of(angle_cos);

endmodule

`default_nettype wire

### sv/open_loop_foc_velocity_drive.sv
`default_nettype none

// channel   | dir | beat contents
// in_ch     | in  | target_speed (s16 q7.8 rad/s), elapsed_us (u32)
// out_ch    | out | duty_a, duty_b, duty_c (u16 q16), electrical_angle (u16)
// cfg_ch    | in  | index (0 pair_count, 1 zero_angle_offset, 2 drive_fraction), data
//
// a tick runs the whole sequence from accept to the next accept: the shared
// 36x27 multiplier is used seven times in sequence, one table lookup in between.
// in_ch.ready is high only while the sequencer is idle and out of reset.
// a result waits in the output register; the next tick is accepted meanwhile,
// and the sequencer holds in its last step while a result is still unread.
// rst is synchronous and restores registers and the shaft angle.

module open_loop_foc_velocity_drive #(
  parameter int ANGLE_BITS = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  focv_in_if.sink    in_ch,
  focv_out_if.source out_ch,
  focv_cfg_if.sink   cfg_ch
);
  import focv_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DT    = 12'b000000000010,
    S_GAIN  = 12'b000000000100,
    S_DELTA = 12'b000000001000,
    S_PP    = 12'b000000010000,
    S_EL    = 12'b000000100000,
    S_LOOK  = 12'b000001000000,
    S_KC    = 12'b000010000000,
    S_DA    = 12'b000100000000,
    S_DB    = 12'b001000000000,
    S_DC    = 12'b010000000000,
    S_FIN   = 12'b100000000000
  } state_t;

  state_t state;

  logic [5:0]  pair_count;
  logic [15:0] zero_angle_offset;
  logic [15:0] drive_fraction;
  logic [31:0] mech_angle;

  logic        spd_neg;
  logic [15:0] spd_mag;
  logic [18:0] dt_fix;

  logic [ANGLE_BITS-1:0] el;
  logic signed [17:0]    sin_q;
  logic signed [17:0]    cos_q;
  logic signed [33:0]    k_cos;
  logic [15:0]           duty_a_q;
  logic [15:0]           duty_b_q;

  logic               mul_en;
  logic signed [35:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [62:0] prod;

  logic signed [17:0] sin_val;
  logic signed [17:0] cos_val;

  logic [15:0]           in_mag;
  logic [62:0]           delta_rnd;
  logic [31:0]           delta;
  logic [31:0]           off_full;
  logic [ANGLE_BITS-1:0] off;
  logic [31:0]           el_full;

  logic              out_valid;
  logic [15:0]       out_a;
  logic [15:0]       out_b;
  logic [15:0]       out_c;
  logic [15:0]       out_angle;
  logic              out_free;

  // round a q32 phase term times the drive fraction, centre and clamp
  function automatic logic [15:0] duty_of(input logic signed [62:0] pr);
    logic signed [62:0] rs;
    logic signed [30:0] q;
    logic signed [31:0] d;
    rs = pr + 63'sd2147483648;
    q = rs[62:32];
    d = 32'(q) + 32'sd32768;
    if (d < 32'sd0) begin
      return 16'd0;
    end else if (d > 32'sd65535) begin
      return 16'hffff;
    end else begin
      return d[15:0];
    end
  endfunction

  // speed magnitude of the incoming beat
  assign in_mag = in_ch.target_speed[15] ? 16'(17'h10000 - 17'(unsigned'(in_ch.target_speed)))
                                         : unsigned'(in_ch.target_speed);

  // angle step, rounded
  assign delta_rnd = unsigned'(prod) + 63'd8388608;
  assign delta = delta_rnd[55:24];

  // offset rescaled to the angle width
  assign off_full = {zero_angle_offset, 16'd0};
  assign off = off_full[31 -: ANGLE_BITS];
  assign el_full = 32'({el, (32 - ANGLE_BITS)'(0)});

  assign out_free = !out_valid || out_ch.ready;

  // operand selection for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DT: begin
        mul_a = 36'(spd_mag);
        mul_b = 27'(dt_fix);
      end
      S_GAIN: begin
        mul_a = 36'(unsigned'(prod[34:0]));
        mul_b = 27'(SPEED_GAIN);
      end
      S_PP: begin
        mul_a = 36'(mech_angle[31 -: ANGLE_BITS]);
        mul_b = 27'(pair_count);
      end
      S_KC: begin
        mul_a = 36'(cos_q);
        mul_b = 27'(SQRT3_HALF_Q16);
      end
      S_DA: begin
        mul_a = 36'sd0 - (36'(sin_q) <<< 16);
        mul_b = 27'(drive_fraction);
      end
      S_DB: begin
        mul_a = 36'(k_cos) + (36'(sin_q) <<< 15);
        mul_b = 27'(drive_fraction);
      end
      S_DC: begin
        mul_a = (36'(sin_q) <<< 15) - 36'(k_cos);
        mul_b = 27'(drive_fraction);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  focv_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  focv_sine #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_sine (
    .angle   (el),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mech_angle <= '0;
      pair_count <= PAIR_COUNT_RST;
      zero_angle_offset <= ZERO_OFFSET_RST;
      drive_fraction <= DRIVE_FRACTION_RST;
    end else begin
      // result register fills at the last step, empties when read
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      // register writes
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_PAIR_COUNT:     pair_count <= cfg_ch.data[5:0];
          CFG_ZERO_OFFSET:    zero_angle_offset <= cfg_ch.data;
          CFG_DRIVE_FRACTION: drive_fraction <= cfg_ch.data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            spd_neg <= in_ch.target_speed[15];
            spd_mag <= in_mag;
            if (in_ch.elapsed_us == '0 || in_ch.elapsed_us > DT_MAX_US) begin
              dt_fix <= DT_DEFAULT_US;
            end else begin
              dt_fix <= in_ch.elapsed_us[18:0];
            end
            state <= S_DT;
          end
        end
        S_DT:   state <= S_GAIN;
        S_GAIN: state <= S_DELTA;
        S_DELTA: begin
          mech_angle <= spd_neg ? (mech_angle - delta) : (mech_angle + delta);
          state <= S_PP;
        end
        S_PP: state <= S_EL;
        S_EL: begin
          el <= prod[ANGLE_BITS-1:0] + off;
          state <= S_LOOK;
        end
        S_LOOK: begin
          sin_q <= sin_val;
          cos_q <= cos_val;
          state <= S_KC;
        end
        S_KC: state <= S_DA;
        S_DA: begin
          k_cos <= prod[33:0];
          state <= S_DB;
        end
        S_DB: begin
          duty_a_q <= duty_of(prod);
          state <= S_DC;
        end
        S_DC: begin
          duty_b_q <= duty_of(prod);
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_a <= duty_a_q;
            out_b <= duty_b_q;
            out_c <= duty_of(prod);
            out_angle <= el_full[31:16];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state == S_IDLE) && !rst;
  assign cfg_ch.ready = !rst;

  assign out_ch.valid = out_valid;
  assign out_ch.duty_a = out_a;
  assign out_ch.duty_b = out_b;
  assign out_ch.duty_c = out_c;
  assign out_ch.electrical_angle = out_angle;

endmodule

`default_nettype wire

### sim/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import focv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES = 10;
  localparam int PHASE_TICKS = 125;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam longint ROOT3_HALF = longint'(SQRT3_HALF_Q16);

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [15:0] angle;
  } duty_set_t;

  // tracks rotor position and registers, predicts the duties of every tick
  class duty_scoreboard;
    bit [16:0] sine_quarter [0:SINE_DEPTH];
    bit [5:0]  pair_count;
    bit [15:0] zero_offset;
    bit [15:0] drive_frac;
    bit [31:0] rotor_pos;
    duty_set_t expected_duties [$];
    int        mismatches;

    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      longint          v;
      // quarter-wave sine, taylor series in q30, rounded to q16
      for (int i = 0; i <= SINE_DEPTH; i++) begin
        x = HALF_PI_Q30 * i / SINE_DEPTH;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int k = 1; k <= 6; k++) begin
          term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            acc -= longint'(term);
          end else begin
            acc += longint'(term);
          end
        end
        v = (acc > 0) ? ((acc + 8192) >>> 14) : 0;
        if (v > 65536) begin
          v = 65536;
        end
        sine_quarter[i] = 17'(v);
      end
      pair_count = PAIR_COUNT_RST;
      zero_offset = ZERO_OFFSET_RST;
      drive_frac = DRIVE_FRACTION_RST;
      rotor_pos = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
      case (idx)
        CFG_PAIR_COUNT:     pair_count = value[5:0];
        CFG_ZERO_OFFSET:    zero_offset = value;
        CFG_DRIVE_FRACTION: drive_frac = value;
        default: ;
      endcase
    endfunction

    // signed q16 sine from the mirrored quarter table
    function longint sine_at(bit [15:0] phase);
      int unsigned idx;
      longint      val;
      idx = (int'(phase[13:0]) * SINE_DEPTH) >> 14;
      if (phase[14]) begin
        idx = SINE_DEPTH - idx;
      end
      val = longint'(sine_quarter[idx]);
      return phase[15] ? -val : val;
    endfunction

    // q32 phase term scaled by drive fraction, centred and clamped
    function bit [15:0] duty_of(longint term);
      longint prod;
      longint d;
      prod = term * longint'(drive_frac);
      d = ((prod + (longint'(1) <<< 50) + (longint'(1) <<< 31)) >>> 32)
          - (longint'(1) <<< 18) + 32768;
      if (d < 0) begin
        d = 0;
      end else if (d > 65535) begin
        d = 65535;
      end
      return 16'(d);
    endfunction

    function void note_tick(logic signed [15:0] speed, logic [31:0] dt);
      bit [31:0]       span;
      bit [16:0]       mag;
      longint unsigned step;
      bit [15:0]       el;
      longint          s;
      longint          c;
      duty_set_t       d;
      // bad elapsed time falls back to the default
      span = (dt == 0 || dt > DT_MAX_US) ? 32'(DT_DEFAULT_US) : dt;
      mag = speed[15] ? 17'h10000 - {1'b0, speed} : {1'b0, speed};
      step = (64'(mag) * 64'(span) * 64'(SPEED_GAIN) + 64'h80_0000) >> 24;
      rotor_pos = speed[15] ? rotor_pos - step[31:0] : rotor_pos + step[31:0];
      el = 16'(32'(pair_count) * 32'(rotor_pos[31:16]) + 32'(zero_offset));
      s = sine_at(el);
      c = sine_at(el + QUARTER_TURN);
      d.duty_a = duty_of(-s * 65536);
      d.duty_b = duty_of(ROOT3_HALF * c + 32768 * s);
      d.duty_c = duty_of(32768 * s - ROOT3_HALF * c);
      d.angle = el;
      expected_duties.push_back(d);
    endfunction

    function void check_result(duty_set_t got);
      duty_set_t want;
      if (expected_duties.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected result beat a=%0d b=%0d c=%0d angle=%0d",
                   got.duty_a, got.duty_b, got.duty_c, got.angle);
        end
        return;
      end
      want = expected_duties.pop_front();
      if (got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
          got.duty_c !== want.duty_c || got.angle !== want.angle) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result mismatch: a %0d/%0d b %0d/%0d c %0d/%0d angle %0d/%0d (exp/got)",
                   want.duty_a, got.duty_a, want.duty_b, got.duty_b,
                   want.duty_c, got.duty_c, want.angle, got.angle);
        end
      end
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   ticks_sent;
  int   results_seen;

  duty_scoreboard sb = new();

  focv_in_if  in_ch ();
  focv_out_if out_ch ();
  focv_cfg_if cfg_ch ();

  open_loop_foc_velocity_drive dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  // result sink with random stalls and two long hold-offs
  initial begin : result_sink
    int        hold;
    duty_set_t got;
    hold = 0;
    results_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.duty_a = out_ch.duty_a;
        got.duty_b = out_ch.duty_b;
        got.duty_c = out_ch.duty_c;
        got.angle = out_ch.electrical_angle;
        sb.check_result(got);
        results_seen++;
        if (results_seen == 300 || results_seen == 900) begin
          hold = HOLD_OFF_CYCLES;
        end else if ((results_seen / 90) % 4 == 2) begin
          hold = 0;
        end else begin
          hold = $urandom_range(0, 15);
        end
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // offer one tick after a random gap, valid stays up once accepted
  task automatic send_tick(input logic signed [15:0] speed, input logic [31:0] dt);
    int gap;
    gap = ((ticks_sent / 80) % 4 == 1) ? 0 : int'($urandom_range(0, 15));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.target_speed <= speed;
    in_ch.elapsed_us <= dt;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_tick(speed, dt);
    ticks_sent++;
  endtask

  task automatic rand_tick();
    int          pick;
    logic [31:0] dt;
    case ($urandom_range(0, 3))
      0: pick = int'($urandom_range(0, 65535));
      1: pick = int'($urandom_range(0, 1022)) - 511;
      2: begin
        case ($urandom_range(0, 4))
          0: pick = 32767;
          1: pick = -32768;
          2: pick = 1;
          3: pick = -1;
          default: pick = 0;
        endcase
      end
      default: pick = int'($urandom_range(0, 8192)) - 4096;
    endcase
    case ($urandom_range(0, 7))
      0: dt = 32'd0;
      1: dt = $urandom;
      2: dt = DT_MAX_US + 32'($urandom_range(0, 1));
      3: dt = $urandom_range(1, 500000);
      default: dt = $urandom_range(100, 5000);
    endcase
    send_tick(16'(pick), dt);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and let every outstanding result drain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [15:0] pp_w;
    logic [15:0] off_w;
    logic [15:0] frac_w;
    ticks_sent = 0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.target_speed <= '0;
    in_ch.elapsed_us <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_PAIR_COUNT;
    cfg_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: speed extremes, elapsed time guard on both sides
    send_tick(0, 32'd1000);
    send_tick(32767, 32'd0);
    send_tick(32767, 32'd500000);
    send_tick(-32768, 32'd500000);
    send_tick(-32768, 32'd500001);
    send_tick(-1, 32'hFFFF_FFFF);
    send_tick(1, 32'd1);
    send_tick(256, 32'd250000);
    send_tick(-256, 32'h8000_0000);
    send_tick(12345, 32'd499999);
    wait_idle();

    // 32 pole pairs (upper bits dropped), top offset, large drive fraction saturating the duties
    write_reg(CFG_PAIR_COUNT, 16'hFFE0);
    write_reg(CFG_ZERO_OFFSET, 16'hFFFF);
    write_reg(CFG_DRIVE_FRACTION, 16'hFFFF);
    send_tick(32767, 32'd500000);
    send_tick(-20000, 32'd123456);
    send_tick(100, 32'd1000);
    send_tick(0, 32'd7);
    wait_idle();

    // zero pole pairs freeze the angle, zero drive, unused index ignored
    write_reg(CFG_PAIR_COUNT, 16'h0040);
    write_reg(CFG_DRIVE_FRACTION, 16'd0);
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    send_tick(5000, 32'd1000);
    send_tick(-5000, 32'd1000);
    wait_idle();

    // random phases, each with its own settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          pp_w = 16'd1;
          off_w = 16'd0;
          frac_w = 16'd32768;
        end
        1: begin
          pp_w = {10'($urandom), 6'd63};
          off_w = 16'hFFFF;
          frac_w = 16'hFFFF;
        end
        2: begin
          pp_w = 16'd32;
          off_w = 16'($urandom);
          frac_w = 16'd0;
        end
        default: begin
          pp_w = 16'($urandom);
          off_w = 16'($urandom);
          frac_w = 16'($urandom_range(0, 40000));
        end
      endcase
      write_reg(CFG_PAIR_COUNT, pp_w);
      write_reg(CFG_ZERO_OFFSET, off_w);
      write_reg(CFG_DRIVE_FRACTION, frac_w);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_UNUSED_IDX, 16'($urandom));
      end
      repeat (PHASE_TICKS) rand_tick();
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
